>>> rtl/core/cplb_pkg.sv
`default_nettype none

package cplb_pkg;

  // Default geometry of the log ring.
  localparam int PAGES_DEF = 16;
  localparam int RECORDS_PER_PAGE_DEF = 64;

  // Fixed field widths of the ports.
  localparam int ACT_W = 2;
  localparam int REC_W = 64;
  localparam int PAGE_OUT_W = 4;
  localparam int SLOT_OUT_W = 6;

  // Action codes carried by an input item.
  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  // Memory operation and result flags from the pointer logic.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_valid;
    logic erased;
  } mem_op_t;

endpackage

`default_nettype wire

>>> rtl/core/cplb_ptr.sv
`default_nettype none

module cplb_ptr
  import cplb_pkg::*;
#(
  parameter int PAGES = PAGES_DEF,
  parameter int RECORDS_PER_PAGE = RECORDS_PER_PAGE_DEF,
  localparam int TOTAL = PAGES * RECORDS_PER_PAGE,
  localparam int PG_W = $clog2(PAGES),
  localparam int FILL_W = $clog2(RECORDS_PER_PAGE + 1),
  localparam int POS_W = $clog2(TOTAL + 1),
  localparam int ADDR_W = $clog2(TOTAL)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire act_t              act,
  output mem_op_t                op,
  output logic [ADDR_W-1:0]      addr,
  output logic [PG_W-1:0]        wpage,
  output logic [FILL_W-1:0]      wslot,
  output logic                   done
);

  // Pointer state.
  logic [PG_W-1:0]   page_r, page_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              first_app_r, first_app_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [PG_W-1:0]   oldest_r, oldest_nxt;
  logic [POS_W-1:0]  rp_r, rp_nxt;
  logic              first_fetch_r, first_fetch_nxt;
  logic              done_r, done_nxt;

  // Working values.
  logic [PG_W-1:0]   app_page;
  logic [FILL_W-1:0] app_fill;
  logic [PG_W:0]     page_plus2;
  logic [POS_W-1:0]  app_lin;
  logic [POS_W-1:0]  wr_lin;
  logic [POS_W-1:0]  rd_base;
  logic [POS_W-1:0]  rd_wrap;

  // Linear position of the write pointer and of the next read.
  assign wr_lin  = POS_W'(page_r) * POS_W'(RECORDS_PER_PAGE) + POS_W'(fill_r);
  assign rd_base = first_fetch_r ? POS_W'(oldest_r) * POS_W'(RECORDS_PER_PAGE) : rp_r;
  assign rd_wrap = (rd_base >= POS_W'(TOTAL)) ? '0 : rd_base;
  assign page_plus2 = {1'b0, page_r} + (PG_W+1)'(2);
  assign app_lin = POS_W'(app_page) * POS_W'(RECORDS_PER_PAGE) + POS_W'(app_fill);

  // Next state and memory operation for the item in flight.
  always_comb begin
    page_nxt        = page_r;
    fill_nxt        = fill_r;
    first_app_nxt   = first_app_r;
    wrapped_nxt     = wrapped_r;
    oldest_nxt      = oldest_r;
    rp_nxt          = rp_r;
    first_fetch_nxt = first_fetch_r;
    done_nxt        = done_r;
    op              = '0;
    addr            = '0;
    app_page        = page_r;
    app_fill        = fill_r;
    if (go) begin
      unique case (act)
        ACT_APPEND: begin
          op.wr_en = 1'b1;
          if (first_app_r) begin
            app_page      = '0;
            app_fill      = '0;
            oldest_nxt    = '0;
            first_app_nxt = 1'b0;
            op.erased     = 1'b1;
          end else if (fill_r == FILL_W'(RECORDS_PER_PAGE)) begin
            // Page full: step to the next page, wrapping at the end of the ring.
            app_fill  = '0;
            op.erased = 1'b1;
            if (page_r == PG_W'(PAGES - 1)) begin
              app_page    = '0;
              wrapped_nxt = 1'b1;
              oldest_nxt  = PG_W'(1);
            end else begin
              app_page = page_r + PG_W'(1);
              if (!wrapped_r) begin
                oldest_nxt = '0;
              end else if (page_plus2 == (PG_W+1)'(PAGES)) begin
                oldest_nxt = '0;
              end else begin
                oldest_nxt = page_plus2[PG_W-1:0];
              end
            end
          end
          page_nxt = app_page;
          fill_nxt = app_fill + FILL_W'(1);
          addr     = app_lin[ADDR_W-1:0];
        end
        ACT_READ: begin
          first_fetch_nxt = 1'b0;
          // The done check is made before and after the wrap to page 0.
          if (rd_base == wr_lin) begin
            done_nxt = 1'b1;
            rp_nxt   = rd_base;
          end else if (rd_wrap == wr_lin) begin
            done_nxt = 1'b1;
            rp_nxt   = rd_wrap;
          end else begin
            op.rd_en    = 1'b1;
            op.rd_valid = 1'b1;
            addr        = rd_wrap[ADDR_W-1:0];
            rp_nxt      = rd_wrap + POS_W'(1);
          end
        end
        ACT_CLEAR: begin
          done_nxt = 1'b0;
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign wpage = app_page;
  assign wslot = app_fill;
  assign done  = done_r;

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r        <= '0;
      fill_r        <= '0;
      first_app_r   <= 1'b1;
      wrapped_r     <= 1'b0;
      oldest_r      <= '0;
      rp_r          <= '0;
      first_fetch_r <= 1'b1;
      done_r        <= 1'b0;
    end else begin
      page_r        <= page_nxt;
      fill_r        <= fill_nxt;
      first_app_r   <= first_app_nxt;
      wrapped_r     <= wrapped_nxt;
      oldest_r      <= oldest_nxt;
      rp_r          <= rp_nxt;
      first_fetch_r <= first_fetch_nxt;
      done_r        <= done_nxt;
    end
  end

  // A single memory port: never a write and a read together.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(op.wr_en && op.rd_en))
    else $error("write and read issued together");

  // The fill count never passes a full page.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(RECORDS_PER_PAGE))
    else $error("write fill beyond page size");

  // Once the ring has wrapped, the oldest page is the one after the write page.
  a_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    (wrapped_r && go && act == ACT_APPEND) |=>
      (oldest_r == ((page_r == PG_W'(PAGES - 1)) ? '0 : page_r + PG_W'(1))))
    else $error("oldest page does not follow the write page");

endmodule

`default_nettype wire

>>> rtl/core/cyclic_page_log_buffer_unit.sv
`default_nettype none

// Channel   Handshake                  Payload
// input     start, busy (accept when   in_action, in_record_hi, in_record_lo
//           start & !busy)
// result    out_valid (one cycle)      out_read_hi, out_read_lo, out_read_valid,
//                                      out_download_done, out_written_page,
//                                      out_written_slot, out_page_erased
//
// An item is registered at accept; the pointer update and the single-port log
// memory access happen at the next edge, and the result shows in the cycle after
// that. busy is high for the one cycle between accept and that edge, so a new item
// may be accepted at the edge that ends its predecessor's result cycle.
// Reset clears the pointers; the log memory is not cleared. The receiver cannot
// stall: each result is shown for exactly one cycle.

module cyclic_page_log_buffer_unit
  import cplb_pkg::*;
#(
  parameter int PAGES = PAGES_DEF,
  parameter int RECORDS_PER_PAGE = RECORDS_PER_PAGE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ACT_W-1:0]      in_action,
  input  wire logic [REC_W-1:0]      in_record_hi,
  input  wire logic [REC_W-1:0]      in_record_lo,
  output logic                       out_valid,
  output logic [REC_W-1:0]           out_read_hi,
  output logic [REC_W-1:0]           out_read_lo,
  output logic                       out_read_valid,
  output logic                       out_download_done,
  output logic [PAGE_OUT_W-1:0]      out_written_page,
  output logic [SLOT_OUT_W-1:0]      out_written_slot,
  output logic                       out_page_erased
);

  localparam int TOTAL = PAGES * RECORDS_PER_PAGE;
  localparam int PG_W = $clog2(PAGES);
  localparam int FILL_W = $clog2(RECORDS_PER_PAGE + 1);
  localparam int ADDR_W = $clog2(TOTAL);

  logic              pend_r;
  logic              accept;
  logic [ACT_W-1:0]  act_r;
  logic [REC_W-1:0]  hi_r;
  logic [REC_W-1:0]  lo_r;

  mem_op_t           op;
  logic [ADDR_W-1:0] addr;
  logic [PG_W-1:0]   wpage;
  logic [FILL_W-1:0] wslot;
  logic              done;

  logic [PG_W+PAGE_OUT_W-1:0]   wpage_ext;
  logic [FILL_W+SLOT_OUT_W-1:0] wslot_ext;

  logic                  out_valid_r;
  logic                  rvalid_r;
  logic                  erased_r;
  logic [PAGE_OUT_W-1:0] wpage_r;
  logic [SLOT_OUT_W-1:0] wslot_r;
  logic [REC_W-1:0]      q_hi_r;
  logic [REC_W-1:0]      q_lo_r;

  logic [REC_W-1:0] mem_hi [TOTAL];
  logic [REC_W-1:0] mem_lo [TOTAL];

  assign accept = start && !pend_r;
  assign busy   = pend_r;

  // Item register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      hi_r  <= in_record_hi;
      lo_r  <= in_record_lo;
    end
  end

  // Pointer control.
  cplb_ptr #(
    .PAGES            (PAGES),
    .RECORDS_PER_PAGE (RECORDS_PER_PAGE)
  ) u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (pend_r),
    .act   (act_t'(act_r)),
    .op    (op),
    .addr  (addr),
    .wpage (wpage),
    .wslot (wslot),
    .done  (done)
  );

  // Log memory: one port, read data registered.
  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem_hi[addr] <= hi_r;
      mem_lo[addr] <= lo_r;
    end
    if (op.rd_en) begin
      q_hi_r <= mem_hi[addr];
      q_lo_r <= mem_lo[addr];
    end
  end

  // Fit page and slot to the fixed port widths.
  assign wpage_ext = {{PAGE_OUT_W{1'b0}}, wpage};
  assign wslot_ext = {{SLOT_OUT_W{1'b0}}, wslot};

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
      erased_r    <= 1'b0;
    end else begin
      out_valid_r <= pend_r;
      rvalid_r    <= pend_r && op.rd_valid;
      erased_r    <= pend_r && op.erased;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      wpage_r <= op.wr_en ? wpage_ext[PAGE_OUT_W-1:0] : '0;
      wslot_r <= op.wr_en ? wslot_ext[SLOT_OUT_W-1:0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_hi       = rvalid_r ? q_hi_r : '0;
  assign out_read_lo       = rvalid_r ? q_lo_r : '0;
  assign out_read_valid    = rvalid_r;
  assign out_download_done = done;
  assign out_written_page  = wpage_r;
  assign out_written_slot  = wslot_r;
  assign out_page_erased   = erased_r;

  // Each result follows exactly one item in flight.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(pend_r))
    else $error("result without an item in flight");

  // An item in flight is never followed directly by another.
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r)
    else $error("busy held for more than one cycle");

  // A record read back is only flagged inside a result.
  a_read_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_read_valid |-> out_valid)
    else $error("read data flagged outside a result");

  // A result never flags both a record read back and an erased page.
  a_read_or_erase: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_read_valid && out_page_erased))
    else $error("read and erase in one result");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cplb_pkg::*;

  localparam int PAGES = PAGES_DEF;
  localparam int RPP = RECORDS_PER_PAGE_DEF;
  localparam int TOTAL = PAGES * RPP;
  localparam int ADDR_W = $clog2(TOTAL);

  // One expected result, field for field as the block shows it.
  typedef struct packed {
    logic [REC_W-1:0]      read_hi;
    logic [REC_W-1:0]      read_lo;
    logic                  read_valid;
    logic                  download_done;
    logic [PAGE_OUT_W-1:0] written_page;
    logic [SLOT_OUT_W-1:0] written_slot;
    logic                  page_erased;
  } log_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [ACT_W-1:0]      in_action;
  logic [REC_W-1:0]      in_record_hi;
  logic [REC_W-1:0]      in_record_lo;
  logic                  out_valid;
  logic [REC_W-1:0]      out_read_hi;
  logic [REC_W-1:0]      out_read_lo;
  logic                  out_read_valid;
  logic                  out_download_done;
  logic [PAGE_OUT_W-1:0] out_written_page;
  logic [SLOT_OUT_W-1:0] out_written_slot;
  logic                  out_page_erased;

  cyclic_page_log_buffer_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_record_hi     (in_record_hi),
    .in_record_lo     (in_record_lo),
    .out_valid        (out_valid),
    .out_read_hi      (out_read_hi),
    .out_read_lo      (out_read_lo),
    .out_read_valid   (out_read_valid),
    .out_download_done(out_download_done),
    .out_written_page (out_written_page),
    .out_written_slot (out_written_slot),
    .out_page_erased  (out_page_erased)
  );

  // Shadow copy of the log ring and its pointers.
  logic [REC_W-1:0] shadow_hi [TOTAL];
  logic [REC_W-1:0] shadow_lo [TOTAL];
  logic [3:0]       wr_page = '0;
  logic [6:0]       wr_fill = '0;
  logic             first_append = 1'b1;
  logic             wrapped = 1'b0;
  logic [3:0]       oldest_pg = '0;
  logic [10:0]      rd_pos = '0;
  logic             read_unstarted = 1'b1;
  logic             done_flag = 1'b0;

  log_result_t pending_results[$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake or lost results.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int write_index();
    return int'(wr_page) * RPP + int'(wr_fill);
  endfunction

  // Advance the shadow ring by one item and return the result it must give.
  function automatic log_result_t log_step(act_t act, logic [REC_W-1:0] hi,
                                           logic [REC_W-1:0] lo);
    log_result_t r;
    int w;
    r = '0;
    case (act)
      ACT_APPEND: begin
        if (first_append) begin
          wr_page = '0;
          wr_fill = '0;
          oldest_pg = '0;
          first_append = 1'b0;
          r.page_erased = 1'b1;
        end else if (int'(wr_fill) >= RPP) begin
          if (int'(wr_page) + 1 < PAGES) begin
            wr_page = wr_page + 4'd1;
            oldest_pg = wrapped ? 4'((int'(wr_page) + 1) % PAGES) : 4'd0;
          end else begin
            wr_page = '0;
            wrapped = 1'b1;
            oldest_pg = 4'd1;
          end
          wr_fill = '0;
          r.page_erased = 1'b1;
        end
        w = write_index();
        shadow_hi[w[ADDR_W-1:0]] = hi;
        shadow_lo[w[ADDR_W-1:0]] = lo;
        r.written_page = wr_page;
        r.written_slot = wr_fill[5:0];
        wr_fill = wr_fill + 7'd1;
      end
      ACT_READ: begin
        w = write_index();
        if (read_unstarted) begin
          rd_pos = 11'(int'(oldest_pg) * RPP);
          read_unstarted = 1'b0;
        end
        if (int'(rd_pos) == w) begin
          done_flag = 1'b1;
        end else begin
          // The read position wraps from the end of the ring to page 0.
          if (int'(rd_pos) >= TOTAL) rd_pos = '0;
          if (int'(rd_pos) == w) begin
            done_flag = 1'b1;
          end else begin
            r.read_hi = shadow_hi[rd_pos[ADDR_W-1:0]];
            r.read_lo = shadow_lo[rd_pos[ADDR_W-1:0]];
            r.read_valid = 1'b1;
            rd_pos = rd_pos + 11'd1;
          end
        end
      end
      ACT_CLEAR: done_flag = 1'b0;
      default: ;
    endcase
    r.download_done = done_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [REC_W-1:0] exp_v,
                                      logic [REC_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Compare each result with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    log_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        check_field("read_hi", e.read_hi, out_read_hi);
        check_field("read_lo", e.read_lo, out_read_lo);
        check_field("read_valid", 64'(e.read_valid), 64'(out_read_valid));
        check_field("download_done", 64'(e.download_done), 64'(out_download_done));
        check_field("written_page", 64'(e.written_page), 64'(out_written_page));
        check_field("written_slot", 64'(e.written_slot), 64'(out_written_slot));
        check_field("page_erased", 64'(e.page_erased), 64'(out_page_erased));
      end
    end
  end

  // Offer one item at a falling edge, hold it until accepted, then maybe idle.
  task automatic send_item(act_t act, logic [REC_W-1:0] hi, logic [REC_W-1:0] lo);
    int r;
    int gap;
    start <= 1'b1;
    in_action <= act;
    in_record_hi <= hi;
    in_record_lo <= lo;
    do @(posedge clk); while (busy);
    pending_results.push_back(log_step(act, hi, lo));
    @(negedge clk);
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [REC_W-1:0] rand_record();
    return {$urandom, $urandom};
  endfunction

  // Weighted choice of action; what is left over goes to the unused code.
  function automatic act_t pick_action(int p_append, int p_read, int p_clear);
    int r;
    r = $urandom_range(0, 99);
    if (r < p_append) return ACT_APPEND;
    if (r < p_append + p_read) return ACT_READ;
    if (r < p_append + p_read + p_clear) return ACT_CLEAR;
    return ACT_NONE;
  endfunction

  // Empty-buffer reads, clear, the unused action, extreme records and read-back.
  task automatic test_directed();
    send_item(ACT_READ, '0, '0);
    send_item(ACT_READ, '1, '1);
    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_NONE, '1, '1);
    send_item(ACT_APPEND, '0, '0);
    send_item(ACT_APPEND, '1, '1);
    send_item(ACT_APPEND, {32{2'b10}}, {32{2'b01}});
    send_item(ACT_APPEND, {32{2'b01}}, {32{2'b10}});
    send_item(ACT_APPEND, {1'b1, 63'd0}, 64'd1);
    repeat (5) send_item(ACT_READ, '0, '0);
    // Reader has met the writer: no record, the flag goes up and stays up.
    send_item(ACT_READ, '0, '0);
    send_item(ACT_READ, '0, '0);
    // A fresh append lets reads go on while the flag is still set.
    send_item(ACT_APPEND, rand_record(), rand_record());
    send_item(ACT_READ, '0, '0);
    send_item(ACT_CLEAR, '1, '1);
    send_item(ACT_NONE, '0, '0);
    send_item(ACT_READ, '0, '0);
  endtask

  // Fill the ring up to its very end with reads, clears and no-ops mixed in.
  task automatic test_fill_ring();
    int n;
    n = 0;
    while (write_index() < TOTAL) begin
      if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      send_item(pick_action(60, 37, 2), rand_record(), rand_record());
      n++;
    end
    steady = 1'b0;
  endtask

  // Read until the reader meets the writer at the end of the ring.
  task automatic test_drain_reads();
    send_item(ACT_CLEAR, rand_record(), rand_record());
    while (!done_flag) send_item(ACT_READ, rand_record(), rand_record());
    send_item(ACT_READ, rand_record(), rand_record());
  endtask

  // Wrap the writer, then run bursts that are append-heavy or read-heavy at random.
  task automatic test_wrap_mix();
    int len;
    bit read_heavy;
    send_item(ACT_APPEND, rand_record(), rand_record());
    send_item(ACT_READ, rand_record(), rand_record());
    send_item(ACT_READ, rand_record(), rand_record());
    for (int b = 0; b < 8; b++) begin
      len = $urandom_range(5, 15);
      read_heavy = 1'($urandom_range(0, 1));
      steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        if (read_heavy) send_item(pick_action(10, 82, 5), rand_record(), rand_record());
        else send_item(pick_action(82, 12, 4), rand_record(), rand_record());
      end
      if (b == 4) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_NONE;
    in_record_hi = '0;
    in_record_lo = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_directed();
    // Hold the sender off until everything has come back.
    wait_drained();
    test_fill_ring();
    test_drain_reads();
    test_wrap_mix();
    wait_drained();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
